@@ rtl/overlay_row_rle_encoder_core_defines.svh @@
// Assertion macros for the row run-length encoder checker.
// No dependencies; included by orre_checker.sv.
`ifndef OVERLAY_ROW_RLE_ENCODER_CORE_DEFINES_SVH
`define OVERLAY_ROW_RLE_ENCODER_CORE_DEFINES_SVH

// Implication checked in the next cycle, clocked on clk_i, quiet in reset.
`define ORRE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("orre: next-cycle check failed");

// Implication checked in the same cycle.
`define ORRE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("orre: same-cycle check failed");

`endif

@@ rtl/orre_pkg.sv @@
// Types and constants shared by the row run-length encoder modules.
// No dependencies.
package orre_pkg;

  localparam int unsigned MaxRun   = 4096;
  localparam int unsigned CountW   = 13;
  localparam int unsigned CountMax = (1 << CountW) - 1;
  // The count saturates at the smaller of the run limit and the field maximum, but at least one.
  localparam int unsigned RunLimit = (MaxRun > CountMax) ? CountMax :
                                     ((MaxRun < 1) ? 1 : MaxRun);
  localparam logic [CountW-1:0] RunLimitC = CountW'(RunLimit);

  typedef struct packed {
    logic [7:0] pixel_index;
    logic       row_last;
  } pixel_t;

  typedef struct packed {
    logic [7:0]        run_index;
    logic [CountW-1:0] run_count;
    logic              closes_row;
    logic              final_result;
  } run_t;

  // Up to two results produced by one pixel, in delivery order.
  typedef struct packed {
    logic v0;
    run_t r0;
    logic v1;
    run_t r1;
  } run_pair_t;

endpackage

@@ rtl/orre_run_tracker.sv @@
// Input register, open-run state and per-pixel run logic.
// Depends on orre_pkg.
module orre_run_tracker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  orre_pkg::pixel_t   in_data_i,
  input  logic               room_i,
  output logic               fire_o,
  output orre_pkg::run_pair_t pair_o
);
  import orre_pkg::*;

  logic              in_vld_q, in_vld_d;
  pixel_t            in_pix_q;
  logic [7:0]        open_idx_q, open_idx_d;
  logic [CountW-1:0] open_cnt_q, open_cnt_d;

  logic              has_open, change;
  logic [7:0]        new_idx;
  logic [CountW-1:0] new_cnt;

  assign fire_o     = in_vld_q && room_i;
  assign in_stall_o = in_vld_q && !room_i;
  assign in_vld_d   = in_stall_o ? 1'b1 : in_valid_i;

  always_comb begin
    has_open = (open_cnt_q != '0);
    change   = has_open && (in_pix_q.pixel_index != open_idx_q);
    if (!has_open || change) begin
      new_idx = in_pix_q.pixel_index;
      new_cnt = CountW'(1);
    end else begin
      new_idx = open_idx_q;
      new_cnt = (open_cnt_q < RunLimitC) ? open_cnt_q + CountW'(1) : open_cnt_q;
    end

    pair_o.v0              = in_vld_q && change;
    pair_o.r0.run_index    = open_idx_q;
    pair_o.r0.run_count    = open_cnt_q;
    pair_o.r0.closes_row   = 1'b0;
    pair_o.r0.final_result = !in_pix_q.row_last;
    pair_o.v1              = in_vld_q && in_pix_q.row_last;
    pair_o.r1.run_index    = new_idx;
    pair_o.r1.run_count    = new_cnt;
    pair_o.r1.closes_row   = 1'b1;
    pair_o.r1.final_result = 1'b1;

    open_idx_d = open_idx_q;
    open_cnt_d = open_cnt_q;
    if (fire_o) begin
      open_idx_d = new_idx;
      open_cnt_d = in_pix_q.row_last ? '0 : new_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      open_idx_q <= '0;
      open_cnt_q <= '0;
    end else begin
      in_vld_q   <= in_vld_d;
      open_idx_q <= open_idx_d;
      open_cnt_q <= open_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_pix_q <= in_data_i;
    end
  end

endmodule

@@ rtl/orre_out_queue.sv @@
// Two-entry result queue that takes up to two runs per cycle and drives
// the output channel. Depends on orre_pkg.
module orre_out_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  orre_pkg::run_pair_t pair_i,
  input  logic                push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output orre_pkg::run_t      out_data_o
);
  import orre_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  run_t       ent_q [2];
  run_t       ent_d [2];
  logic       pop;
  logic [1:0] cnt_pop, n_res;
  run_t       first;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = ent_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  assign cnt_pop     = cnt_q - {1'b0, pop};
  assign n_res       = {1'b0, pair_i.v0} + {1'b0, pair_i.v1};
  assign room_o      = ({1'b0, cnt_pop} + {1'b0, n_res}) <= 3'd2;
  assign first       = pair_i.v0 ? pair_i.r0 : pair_i.r1;

  always_comb begin
    ent_d = ent_q;
    if (pop) begin
      ent_d[0] = ent_q[1];
    end
    if (push_i && (n_res != 2'd0)) begin
      ent_d[cnt_pop[0]] = first;
      // Two results only fit into an empty queue, so the second lands in slot one.
      if (n_res == 2'd2) begin
        ent_d[1] = pair_i.r1;
      end
    end
    cnt_d = cnt_pop + (push_i ? n_res : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

@@ rtl/overlay_row_rle_encoder_core.sv @@
// Top level of the row-bounded run-length encoder for palette pixels.
// Depends on orre_pkg, orre_run_tracker and orre_out_queue.
//
//   channel | direction | beat     | handshake
//   in      | input     | pixel_t  | in_valid_i / in_stall_o
//   out     | output    | run_t    | out_valid_o / out_stall_i
//
// One pixel is taken per cycle while in_stall_o is low; after acceptance a pixel
// reaches its results through the input register, then the result queue.
// A row-end pixel that also changes color yields two beats, so the output port
// sets the rate: one result beat per cycle when not stalled, drained from a two-entry queue.
// Reset clears the open run and empties both stages; no clearing pass.
// Output stalls back up into the input register and then onto in_stall_o.
module overlay_row_rle_encoder_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  orre_pkg::pixel_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output orre_pkg::run_t   out_data_o
);
  import orre_pkg::*;

  run_pair_t pair;
  logic      room, fire;

  orre_run_tracker u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .room_i     (room),
    .fire_o     (fire),
    .pair_o     (pair)
  );

  orre_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pair_i      (pair),
    .push_i      (fire),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/orre_checker.sv @@
// Port-level checks for overlay_row_rle_encoder_core, bound to the top level.
// Depends on orre_pkg and overlay_row_rle_encoder_core_defines.svh.
`include "overlay_row_rle_encoder_core_defines.svh"

module orre_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input orre_pkg::pixel_t in_data_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input orre_pkg::run_t   out_data_o
);
  import orre_pkg::*;

  // A stalled result beat stays offered.
  `ORRE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // The run that closes a row is always the last result of its pixel.
  `ORRE_ASSERT_NOW(a_close_final, out_valid_o && out_data_o.closes_row,
                   out_data_o.final_result)

  // A non-final result is followed at once by the row-closing run.
  `ORRE_ASSERT_NEXT(a_pair_order,
                    out_valid_o && !out_stall_i && !out_data_o.final_result,
                    out_valid_o && out_data_o.closes_row)

  // Every emitted run holds at least one pixel.
  `ORRE_ASSERT_NOW(a_count_nonzero, out_valid_o, out_data_o.run_count != '0)

endmodule

bind overlay_row_rle_encoder_core orre_checker u_orre_checker (.*);
